### rtl/core/ordered_list_insert_remove_find_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ordered list block
// Checks fall away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_INSERT_REMOVE_FIND_DEFINES_SVH
`define ORDERED_LIST_INSERT_REMOVE_FIND_DEFINES_SVH

`ifndef SYNTHESIS
`define OLIRF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define OLIRF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define OLIRF_ASSERT(label, prop, msg)
`define OLIRF_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

### rtl/core/olirf_pkg.sv
// ----------------------------------------------------------------------------
// olirf_pkg
// Field widths, operation and status codes and cell control for the list.
// ----------------------------------------------------------------------------
package olirf_pkg;

	localparam int MODE_W   = 3;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 7;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;

	localparam int DEPTH_DEF      = 64;
	localparam int DATA_WIDTH_DEF = 32;

	typedef enum logic [MODE_W-1:0] {
		MODE_APPEND      = 3'd0,
		MODE_INSERT_AT   = 3'd1,
		MODE_REMOVE_LAST = 3'd2,
		MODE_REMOVE_AT   = 3'd3,
		MODE_FIND        = 3'd4,
		MODE_READ_AT     = 3'd5
	} mode_e_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_BADPOS = 2'd1,
		ST_FULL   = 2'd2,
		ST_EMPTY  = 2'd3
	} status_e_t;

	// Broadcast to every cell of the row for one request.
	typedef struct packed {
		logic load;    // request accepted: capture compare and read taps
		logic insert;  // shift up above the index, write the word at the index
		logic remove;  // shift down from the index
		logic cmp;     // find: compare valid entries with the word
		logic rd;      // read: the cell at the index drives its entry
	} cell_ctrl_t;

endpackage

### rtl/core/olirf_req_if.sv
// ----------------------------------------------------------------------------
// olirf_req_if
// Request channel of the ordered list: operation, word and position.
// ----------------------------------------------------------------------------
interface olirf_req_if;
	import olirf_pkg::*;

	logic               valid;
	logic               ready;
	logic [MODE_W-1:0]  mode;
	logic [VALUE_W-1:0] value;
	logic [POS_W-1:0]   position;

	modport source (output valid, output mode, output value, output position, input ready);
	modport sink (input valid, input mode, input value, input position, output ready);
endinterface

### rtl/core/olirf_rsp_if.sv
// ----------------------------------------------------------------------------
// olirf_rsp_if
// Result channel of the ordered list: status, found position, word, count.
// ----------------------------------------------------------------------------
interface olirf_rsp_if;
	import olirf_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [POS_W-1:0]    found_position;
	logic [VALUE_W-1:0]  read_value;
	logic [COUNT_W-1:0]  entry_count;

	modport source (output valid, output status, output found_position, output read_value,
		output entry_count, input ready);
	modport sink (input valid, input status, input found_position, input read_value,
		input entry_count, output ready);
endinterface

### rtl/core/olirf_cell.sv
// ----------------------------------------------------------------------------
// olirf_cell
// One list entry: shifts to or from its neighbours, compares and reads out.
// ----------------------------------------------------------------------------
module olirf_cell #(
	parameter int IDX = 0,
	parameter int IW  = 6,
	parameter int CW  = 7,
	parameter int KW  = 32
) (
	input  logic                   clk,
	input  olirf_pkg::cell_ctrl_t  ctrl,
	input  logic [IW-1:0]          k,
	input  logic [CW-1:0]          count,
	input  logic [KW-1:0]          word,
	input  logic [KW-1:0]          left,
	input  logic [KW-1:0]          right,
	output logic [KW-1:0]          data,
	output logic                   match,
	output logic [KW-1:0]          rdat
);
	import olirf_pkg::*;

	localparam logic [IW-1:0] IDX_K = IW'(IDX);
	localparam logic [CW-1:0] IDX_C = CW'(IDX);

	logic [KW-1:0] data_q;
	logic          match_s1;
	logic [KW-1:0] rdat_s1;

	always_ff @(posedge clk) begin
		if (ctrl.insert) begin
			if (IDX_K > k) begin
				data_q <= left;
			end else if (IDX_K == k) begin
				data_q <= word;
			end
		end else if (ctrl.remove) begin
			if (IDX_K >= k) begin
				data_q <= right;
			end
		end
	end

	// Taps see the entry before this request's shift; find and read never shift.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			match_s1 <= ctrl.cmp && (IDX_C < count) && (data_q == word);
			rdat_s1  <= (ctrl.rd && (IDX_K == k)) ? data_q : '0;
		end
	end

	assign data  = data_q;
	assign match = match_s1;
	assign rdat  = rdat_s1;
endmodule

### rtl/core/olirf_chain.sv
// ----------------------------------------------------------------------------
// olirf_chain
// Row of list cells with the first-match pick and the read-out merge.
// ----------------------------------------------------------------------------
module olirf_chain #(
	parameter int DEPTH = olirf_pkg::DEPTH_DEF,
	parameter int IW    = 6,
	parameter int CW    = 7,
	parameter int KW    = 32
) (
	input  logic                        clk,
	input  olirf_pkg::cell_ctrl_t       ctrl,
	input  logic [IW-1:0]               k,
	input  logic [CW-1:0]               count,
	input  logic [KW-1:0]               word,
	output logic [olirf_pkg::POS_W-1:0] found_position,
	output logic [KW-1:0]               read_word
);
	import olirf_pkg::*;

	logic [KW-1:0]    data_w [DEPTH];
	logic [KW-1:0]    rdat_w [DEPTH];
	logic [DEPTH-1:0] match_w;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [KW-1:0] left_w;
		logic [KW-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = word;
		end else begin : g_inner_l
			assign left_w = data_w[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_w = data_w[i];
		end else begin : g_inner_r
			assign right_w = data_w[i+1];
		end

		olirf_cell #(
			.IDX (i),
			.IW  (IW),
			.CW  (CW),
			.KW  (KW)
		) u_cell (
			.clk   (clk),
			.ctrl  (ctrl),
			.k     (k),
			.count (count),
			.word  (word),
			.left  (left_w),
			.right (right_w),
			.data  (data_w[i]),
			.match (match_w[i]),
			.rdat  (rdat_w[i])
		);
	end

	logic [DEPTH-1:0] first_oh;
	logic [IW-1:0]    first_idx;

	// Lowest set bit isolates the first matching position.
	assign first_oh = match_w & (~match_w + DEPTH'(1));

	always_comb begin
		first_idx = '0;
		read_word = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (first_oh[i]) begin
				first_idx = first_idx | IW'(i);
			end
			read_word = read_word | rdat_w[i];
		end
	end

	assign found_position = (match_w != '0) ? (POS_W'(first_idx) + POS_W'(1)) : '0;
endmodule

### rtl/core/ordered_list_insert_remove_find.sv
// A result goes through the stage-one registers and then the output registers.
// Throughput: one request per cycle while results are taken; the cell row shifts
// and compares in the accept cycle, the first-match pick and read merge follow.
// A waiting result stalls requests only once the middle stage is also occupied.
// Reset clears the entry count and the stage valids; entries are not cleared.
// ----------------------------------------------------------------------------
// ordered_list_insert_remove_find
// Fixed-depth ordered list with append, insert, remove, find and read.
// ----------------------------------------------------------------------------
`include "ordered_list_insert_remove_find_defines.svh"

module ordered_list_insert_remove_find #(
	parameter int DEPTH      = olirf_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = olirf_pkg::DATA_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	olirf_req_if.sink   req,
	olirf_rsp_if.source rsp
);
	import olirf_pkg::*;

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int KW = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;
	localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

	logic [CW-1:0] count_q;
	logic          valid_s1;
	status_e_t     status_s1;
	logic [CW-1:0] count_s1;
	logic          out_valid_q;
	status_e_t     status_q;
	logic [POS_W-1:0]   found_q;
	logic [VALUE_W-1:0] read_q;
	logic [COUNT_W-1:0] count_out_q;

	logic          adv;
	logic          acc;
	logic          full;
	logic          empty;
	logic [XW-1:0] pos_x;
	logic [XW-1:0] cnt_x;
	cell_ctrl_t    ctrl;
	logic [IW-1:0] k;
	logic [CW-1:0] count_nxt;
	status_e_t     status_nxt;
	logic [KW-1:0] word;
	logic [POS_W-1:0] found_w;
	logic [KW-1:0]    read_w;

	assign adv       = !out_valid_q || rsp.ready;
	assign req.ready = !valid_s1 || adv;
	assign acc       = req.valid && req.ready;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign pos_x = XW'(req.position);
	assign cnt_x = XW'(count_q);
	assign word  = req.value[KW-1:0];

	always_comb begin
		ctrl       = '0;
		ctrl.load  = acc;
		k          = IW'(pos_x - XW'(1));
		count_nxt  = count_q;
		status_nxt = ST_OK;
		unique case (req.mode)
			MODE_APPEND: begin
				k = IW'(count_q);
				if (full) begin
					status_nxt = ST_FULL;
				end else begin
					ctrl.insert = acc;
					count_nxt   = count_q + CW'(1);
				end
			end
			MODE_INSERT_AT: begin
				// The position check takes precedence over the full check.
				if (pos_x == '0 || pos_x > cnt_x + XW'(1)) begin
					status_nxt = ST_BADPOS;
				end else if (full) begin
					status_nxt = ST_FULL;
				end else begin
					ctrl.insert = acc;
					count_nxt   = count_q + CW'(1);
				end
			end
			MODE_REMOVE_LAST: begin
				if (empty) begin
					status_nxt = ST_EMPTY;
				end else begin
					count_nxt = count_q - CW'(1);
				end
			end
			MODE_REMOVE_AT: begin
				if (empty) begin
					status_nxt = ST_EMPTY;
				end else if (pos_x == '0 || pos_x > cnt_x) begin
					status_nxt = ST_BADPOS;
				end else begin
					ctrl.remove = acc;
					count_nxt   = count_q - CW'(1);
				end
			end
			MODE_FIND: begin
				ctrl.cmp = 1'b1;
			end
			MODE_READ_AT: begin
				if (pos_x == '0 || pos_x > cnt_x) begin
					status_nxt = ST_BADPOS;
				end else begin
					ctrl.rd = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	olirf_chain #(
		.DEPTH (DEPTH),
		.IW    (IW),
		.CW    (CW),
		.KW    (KW)
	) u_chain (
		.clk            (clk),
		.ctrl           (ctrl),
		.k              (k),
		.count          (count_q),
		.word           (word),
		.found_position (found_w),
		.read_word      (read_w)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				count_q <= count_nxt;
			end
			if (acc) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			status_s1 <= status_nxt;
			count_s1  <= count_nxt;
		end
		if (adv && valid_s1) begin
			status_q    <= status_s1;
			found_q     <= found_w;
			read_q      <= VALUE_W'(read_w);
			count_out_q <= COUNT_W'(count_s1);
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.status         = status_q;
	assign rsp.found_position = found_q;
	assign rsp.read_value     = read_q;
	assign rsp.entry_count    = count_out_q;

	`OLIRF_ASSERT(a_count_bound, count_q <= CW'(DEPTH), "entry count above depth")
	`OLIRF_ASSERT(a_stall_blocks, (valid_s1 && !adv) |-> !req.ready, "request taken into a held stage")
	`OLIRF_ASSERT_NEXT(a_full_append_holds, acc && req.mode == MODE_APPEND && full, count_q == $past(count_q), "append on a full list changed the count")
	`OLIRF_ASSERT(a_full_status, (valid_s1 && status_s1 == ST_FULL) |-> full, "full status while the list has room")
endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ordered list. Requests go in through the
// request channel in bursts with random gaps while the result channel stalls
// on a changing pattern. A behavioural list in the bench predicts each
// result, and every returned result is compared field by field with the
// oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
	import olirf_pkg::*;

	localparam int CLK_HALF_NS = 6;
	localparam int TIMEOUT_NS  = 5_000_000;
	localparam int LIST_DEPTH  = DEPTH_DEF;
	localparam int RANDOM_REQS = 850;
	localparam int LONG_HOLD   = 150;
	localparam int SHOWN_FAILS = 10;

	// Modes 6 and 7 have no operation behind them.
	localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

	typedef struct packed {
		status_e_t           status;
		logic [POS_W-1:0]    found_position;
		logic [VALUE_W-1:0]  read_value;
		logic [COUNT_W-1:0]  entry_count;
	} list_reply_t;

	logic clk;
	logic arst_n;

	olirf_req_if req_bus ();
	olirf_rsp_if rsp_bus ();

	ordered_list_insert_remove_find dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	// Behavioural copy of the list.
	logic [VALUE_W-1:0] list_words [LIST_DEPTH];
	int unsigned        list_len;

	list_reply_t pending_replies [$];
	logic [VALUE_W-1:0] word_pool [12];

	int fail_count;
	int requests_sent;
	int replies_checked;
	int status_tally [4];
	int find_hits;
	int burst_left;
	int hold_order;

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF_NS) clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Timed out with %0d results outstanding", pending_replies.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Applies one operation to the behavioural list and returns its result.
	function automatic list_reply_t apply_list_op(input logic [MODE_W-1:0] op,
			input logic [VALUE_W-1:0] word, input logic [POS_W-1:0] pos);
		list_reply_t r;
		int          p;
		int          i;
		bit          hit;
		r.status         = ST_OK;
		r.found_position = '0;
		r.read_value     = '0;
		p = int'(pos);
		unique case (op)
			MODE_APPEND: begin
				if (list_len >= LIST_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					list_words[list_len] = word;
					list_len++;
				end
			end
			MODE_INSERT_AT: begin
				if (p < 1 || p > list_len + 1) begin
					r.status = ST_BADPOS;
				end else if (list_len >= LIST_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					for (i = list_len; i > p - 1; i--)
						list_words[i] = list_words[i-1];
					list_words[p-1] = word;
					list_len++;
				end
			end
			MODE_REMOVE_LAST: begin
				if (list_len == 0)
					r.status = ST_EMPTY;
				else
					list_len--;
			end
			MODE_REMOVE_AT: begin
				if (list_len == 0) begin
					r.status = ST_EMPTY;
				end else if (p < 1 || p > list_len) begin
					r.status = ST_BADPOS;
				end else begin
					for (i = p - 1; i + 1 < list_len; i++)
						list_words[i] = list_words[i+1];
					list_len--;
				end
			end
			MODE_FIND: begin
				hit = 1'b0;
				for (i = 0; i < list_len; i++) begin
					if (!hit && list_words[i] == word) begin
						hit = 1'b1;
						r.found_position = POS_W'(i + 1);
					end
				end
			end
			MODE_READ_AT: begin
				if (p < 1 || p > list_len)
					r.status = ST_BADPOS;
				else
					r.read_value = list_words[p-1];
			end
			default: ;
		endcase
		r.entry_count = COUNT_W'(list_len);
		return r;
	endfunction

	// Offers one request, waits for it to be taken and records its result.
	task automatic send_request(input logic [MODE_W-1:0] op, input logic [VALUE_W-1:0] word,
			input logic [POS_W-1:0] pos);
		int          gap;
		list_reply_t r;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				req_bus.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_bus.valid    <= 1'b1;
		req_bus.mode     <= op;
		req_bus.value    <= word;
		req_bus.position <= pos;
		do @(posedge clk); while (!req_bus.ready);
		r = apply_list_op(op, word, pos);
		pending_replies.push_back(r);
		requests_sent++;
		status_tally[r.status]++;
		if (op == MODE_FIND && r.found_position != 0)
			find_hits++;
	endtask

	// Stops offering requests until every outstanding result has come back.
	task automatic wait_for_replies();
		int guard;
		guard = 0;
		req_bus.valid <= 1'b0;
		burst_left = 0;
		while (pending_replies.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (6) @(posedge clk);
	endtask

	function automatic logic [VALUE_W-1:0] pick_word();
		if ($urandom_range(0, 99) < 65)
			return word_pool[$urandom_range(0, 11)];
		return $urandom;
	endfunction

	task automatic test_empty_list_cases();
		send_request(MODE_REMOVE_LAST, 32'h0, 7'd0);
		send_request(MODE_REMOVE_AT, 32'h0, 7'd0);
		send_request(MODE_REMOVE_AT, 32'h0, 7'd127);
		send_request(MODE_READ_AT, 32'h0, 7'd1);
		send_request(MODE_FIND, 32'h0, 7'd0);
		send_request(MODE_SPARE_LO, 32'hFFFF_FFFF, 7'd1);
		send_request(MODE_SPARE_HI, 32'h1234_5678, 7'd3);
		send_request(MODE_INSERT_AT, 32'h1111_1111, 7'd0);
		send_request(MODE_INSERT_AT, 32'h1111_1111, 7'd2);
		send_request(MODE_INSERT_AT, 32'h1111_1111, 7'd1);
	endtask

	task automatic test_middle_edits();
		send_request(MODE_APPEND, 32'hFFFF_FFFF, 7'd0);
		send_request(MODE_APPEND, 32'h0000_0000, 7'd0);
		send_request(MODE_INSERT_AT, 32'hA5A5_5A5A, 7'd2);
		send_request(MODE_INSERT_AT, 32'h0BAD_F00D, 7'd5);
		send_request(MODE_FIND, 32'h0000_0000, 7'd0);
		send_request(MODE_FIND, 32'hDEAD_BEEF, 7'd0);
		send_request(MODE_READ_AT, 32'h0, 7'd1);
		send_request(MODE_READ_AT, 32'h0, 7'd5);
		send_request(MODE_READ_AT, 32'h0, 7'd6);
		send_request(MODE_READ_AT, 32'h0, 7'd127);
		send_request(MODE_REMOVE_AT, 32'h0, 7'd0);
		send_request(MODE_REMOVE_AT, 32'h0, 7'd6);
		send_request(MODE_REMOVE_AT, 32'h0, 7'd2);
		send_request(MODE_REMOVE_LAST, 32'h0, 7'd0);
	endtask

	// Fills the list while the result side holds off, so the block backs up.
	task automatic test_fill_to_capacity();
		hold_order <= LONG_HOLD;
		while (list_len < LIST_DEPTH)
			send_request(MODE_APPEND, $urandom, 7'd0);
		send_request(MODE_APPEND, 32'h5555_AAAA, 7'd0);
		send_request(MODE_INSERT_AT, 32'h5555_AAAA, 7'd1);
		send_request(MODE_INSERT_AT, 32'h5555_AAAA, 7'd65);
		send_request(MODE_INSERT_AT, 32'h5555_AAAA, 7'd66);
		send_request(MODE_INSERT_AT, 32'h5555_AAAA, 7'd0);
		send_request(MODE_READ_AT, 32'h0, 7'd64);
		send_request(MODE_FIND, list_words[LIST_DEPTH-1], 7'd0);
		send_request(MODE_REMOVE_AT, 32'h0, 7'd64);
		send_request(MODE_INSERT_AT, 32'h7777_0000, 7'd64);
		send_request(MODE_REMOVE_AT, 32'h0, 7'd1);
		send_request(MODE_INSERT_AT, 32'h8888_0000, 7'd1);
		wait_for_replies();
	endtask

	task automatic test_random_traffic();
		int  n;
		int  roll;
		int  top;
		bit  grow;
		logic [MODE_W-1:0] op;
		logic [POS_W-1:0]  pos;
		grow = 1'b0;
		for (n = 0; n < RANDOM_REQS; n++) begin
			if (list_len == LIST_DEPTH)
				grow = 1'b0;
			else if (list_len == 0)
				grow = 1'b1;
			else if ($urandom_range(0, 39) == 0)
				grow = ~grow;
			roll = $urandom_range(0, 99);
			if (roll < 2)
				op = roll[0] ? MODE_SPARE_HI : MODE_SPARE_LO;
			else if (grow)
				op = (roll < 32) ? MODE_APPEND : (roll < 52) ? MODE_INSERT_AT :
					(roll < 60) ? MODE_REMOVE_LAST : (roll < 68) ? MODE_REMOVE_AT :
					(roll < 84) ? MODE_FIND : MODE_READ_AT;
			else
				op = (roll < 12) ? MODE_APPEND : (roll < 22) ? MODE_INSERT_AT :
					(roll < 42) ? MODE_REMOVE_LAST : (roll < 62) ? MODE_REMOVE_AT :
					(roll < 81) ? MODE_FIND : MODE_READ_AT;
			// Mostly positions that hit the list, now and then any 7-bit value.
			top = (op == MODE_INSERT_AT) ? list_len + 1 : (list_len == 0 ? 1 : list_len);
			if ($urandom_range(0, 99) < 88)
				pos = POS_W'($urandom_range(1, top));
			else
				pos = POS_W'($urandom_range(0, 127));
			send_request(op, pick_word(), pos);
			if (n == RANDOM_REQS / 2)
				wait_for_replies();
		end
	endtask

	// Result side: a stall pattern that changes every so often, plus a long
	// hold when the stimulus orders one.
	initial begin : result_stall
		int hold_left;
		int style;
		int phase_left;
		int tick;
		rsp_bus.ready = 1'b0;
		hold_order = 0;
		hold_left = 0;
		phase_left = 0;
		style = 0;
		tick = 0;
		forever begin
			@(posedge clk);
			tick++;
			if (hold_order != 0) begin
				hold_left = hold_order;
				hold_order <= 0;
			end
			if (phase_left == 0) begin
				phase_left = $urandom_range(20, 80);
				style = $urandom_range(0, 3);
			end
			phase_left--;
			if (hold_left != 0) begin
				hold_left--;
				rsp_bus.ready <= 1'b0;
			end else begin
				unique case (style)
					0: rsp_bus.ready <= 1'b1;
					1: rsp_bus.ready <= 1'($urandom_range(0, 1));
					2: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
					default: rsp_bus.ready <= (tick % 4 != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin : check_replies
		list_reply_t want;
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			replies_checked++;
			if (pending_replies.size() == 0) begin
				fail_count++;
				if (fail_count <= SHOWN_FAILS)
					$display("%0t: result with nothing outstanding: st=%0d pos=%0d rd=%h cnt=%0d",
						$realtime, rsp_bus.status, rsp_bus.found_position,
						rsp_bus.read_value, rsp_bus.entry_count);
			end else begin
				want = pending_replies.pop_front();
				if (rsp_bus.status !== want.status ||
						rsp_bus.found_position !== want.found_position ||
						rsp_bus.read_value !== want.read_value ||
						rsp_bus.entry_count !== want.entry_count) begin
					fail_count++;
					if (fail_count <= SHOWN_FAILS)
						$display("%0t: wrong result, exp st=%0d pos=%0d rd=%h cnt=%0d, %s",
							$realtime, want.status, want.found_position, want.read_value,
							want.entry_count,
							$sformatf("got st=%0d pos=%0d rd=%h cnt=%0d",
								rsp_bus.status, rsp_bus.found_position,
								rsp_bus.read_value, rsp_bus.entry_count));
				end
			end
		end
	end

	initial begin : run_tests
		int i;
		arst_n = 1'b0;
		req_bus.valid = 1'b0;
		req_bus.mode = MODE_APPEND;
		req_bus.value = '0;
		req_bus.position = '0;
		list_len = 0;
		for (i = 0; i < LIST_DEPTH; i++)
			list_words[i] = '0;
		for (i = 0; i < 4; i++)
			status_tally[i] = 0;
		fail_count = 0;
		requests_sent = 0;
		replies_checked = 0;
		find_hits = 0;
		burst_left = 0;
		word_pool[0] = 32'h0000_0000;
		word_pool[1] = 32'hFFFF_FFFF;
		for (i = 2; i < 12; i++)
			word_pool[i] = $urandom;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list_cases();
		test_middle_edits();
		wait_for_replies();
		test_fill_to_capacity();
		test_random_traffic();
		wait_for_replies();

		if (pending_replies.size() != 0) begin
			fail_count += pending_replies.size();
			$display("%0d results never arrived", pending_replies.size());
		end
		$display("Covered %0d requests and %0d results: ok %0d, bad position %0d, full %0d, empty %0d",
			requests_sent, replies_checked, status_tally[ST_OK], status_tally[ST_BADPOS],
			status_tally[ST_FULL], status_tally[ST_EMPTY]);
		$display("Searches that found a word: %0d; failures counted: %0d", find_hits, fail_count);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/olirf_pkg.sv
rtl/core/olirf_req_if.sv
rtl/core/olirf_rsp_if.sv
rtl/core/olirf_cell.sv
rtl/core/olirf_chain.sv
rtl/core/ordered_list_insert_remove_find.sv
sim/tb_top.sv
